// ===== rtl/core/vftp_pkg.sv =====
package vftp_pkg;

   // input item codes
   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_SPEED  = 2'd1;
   localparam logic [1:0] KIND_ENABLE = 2'd2;

   // register indexes
   localparam logic [1:0] REG_MIN_FREQ = 2'd0;
   localparam logic [1:0] REG_MAX_FREQ = 2'd1;
   localparam logic [1:0] REG_DUAL     = 2'd2;

   localparam logic [7:0] MIN_FREQ_RESET = 8'd20;
   localparam logic [7:0] MAX_FREQ_RESET = 8'd100;

   localparam logic [6:0]  DUTY_MAX    = 7'd100;
   localparam logic [6:0]  DUTY_KNEE   = 7'd10;
   localparam logic [7:0]  DUTY_SPAN   = 8'd90;
   localparam logic [14:0] PERIOD_US   = 15'd10000;
   localparam logic [13:0] ELAPSED_MAX = 14'd16383;

   // serial engine step counts, loaded as count minus one
   localparam logic [3:0] MUL_LAST = 4'd6;
   localparam logic [3:0] DIV_LAST = 4'd14;

   typedef struct packed {
      logic [1:0]        kind;
      logic signed [7:0] speed;
      logic              enable;
   } req_type;

   typedef struct packed {
      logic forward_out;
      logic reverse_out;
      logic enabled;
   } rsp_type;

endpackage

// ===== rtl/core/variable_frequency_track_pwm.sv =====
// Variable-frequency PWM drive for model railway track power.
//
// Channels: req_* carries one item per transfer (kind, speed, enable); rsp_*
// returns exactly one result per item with the forward/reverse levels and the
// enable state as they stand after that item. csr_* writes min_frequency (0),
// max_frequency (1) and dual_output_mode (2); other indexes are dropped.
// csr_ready is always high; write only while the block is idle.
//
// Timing: a tick or set-enable item's result is in the output register on
// the cycle after it is accepted. A set-speed item posts its result at once,
// then runs a bit-serial engine: a shift-add multiply, a restoring divide by
// 90 and a divide of 10000 by the frequency (the first two are skipped when
// the duty is 10 or less); req_ready stays low while the engine runs.
// The single result register decouples the sides: a new item is accepted in
// the same cycle the held result is taken. If rsp_ready stays low, the
// result holds and req_ready drops until it leaves.
//
// Reset (synchronous, active high): all drive state is zero, registers return
// to min 20, max 100, single-pin mode, and no result is pending.
module variable_frequency_track_pwm
   import vftp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;

   // configuration
   logic [7:0]  min_freq_ff, min_freq_in;
   logic [7:0]  max_freq_ff, max_freq_in;
   logic        dual_ff, dual_in;

   // drive state
   logic [6:0]  step_ff, step_in;
   logic [6:0]  active_duty_ff, active_duty_in;
   logic [13:0] active_interval_ff, active_interval_in;
   logic [6:0]  pending_duty_ff, pending_duty_in;
   logic [13:0] pending_interval_ff, pending_interval_in;
   logic [7:0]  speed_held_ff, speed_held_in;
   logic [13:0] elapsed_ff, elapsed_in;
   logic        fwd_ff, fwd_in;
   logic        rev_ff, rev_in;
   logic        en_ff, en_in;

   // serial arithmetic engine
   logic [1:0]  state_ff, state_in;
   logic        div_phase_ff, div_phase_in;   // 0: divide by 90, 1: 10000 / f
   logic        neg_ff, neg_in;               // max below min
   logic [3:0]  cnt_ff, cnt_in;
   logic [7:0]  rem_ff, rem_in;
   logic [14:0] quo_ff, quo_in;               // also the multiply accumulator
   logic [7:0]  divisor_ff, divisor_in;       // multiplicand during multiply
   logic [6:0]  mplier_ff, mplier_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        req_take;
   logic [7:0]  mag;
   logic [6:0]  duty;
   logic [9:0]  trial;
   logic        trial_neg;
   logic [7:0]  freq_sum;
   logic [7:0]  freq;
   logic [13:0] elapsed_inc;
   logic        pwm_fire;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // magnitude of the command, -128 maps to zero, clamped to 100
   always_comb begin
      if (req_data.speed == -8'sd128) begin
         mag = 8'd0;
      end else if (req_data.speed[7]) begin
         mag = 8'(-req_data.speed);
      end else begin
         mag = 8'(req_data.speed);
      end
      duty = (mag > {1'b0, DUTY_MAX}) ? DUTY_MAX : mag[6:0];
   end

   // one restoring divide step
   assign trial     = {1'b0, rem_ff, quo_ff[14]} - {2'b00, divisor_ff};
   assign trial_neg = trial[9];

   // frequency from the quotient including the bit this step produces
   assign freq_sum = neg_ff ? (min_freq_ff - {quo_ff[6:0], !trial_neg})
                            : (min_freq_ff + {quo_ff[6:0], !trial_neg});

   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 14'd1;

   always_comb begin
      min_freq_in         = min_freq_ff;
      max_freq_in         = max_freq_ff;
      dual_in             = dual_ff;
      step_in             = step_ff;
      active_duty_in      = active_duty_ff;
      active_interval_in  = active_interval_ff;
      pending_duty_in     = pending_duty_ff;
      pending_interval_in = pending_interval_ff;
      speed_held_in       = speed_held_ff;
      elapsed_in          = elapsed_ff;
      fwd_in              = fwd_ff;
      rev_in              = rev_ff;
      en_in               = en_ff;
      state_in            = state_ff;
      div_phase_in        = div_phase_ff;
      neg_in              = neg_ff;
      cnt_in              = cnt_ff;
      rem_in              = rem_ff;
      quo_in              = quo_ff;
      divisor_in          = divisor_ff;
      mplier_in           = mplier_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_data_in         = rsp_data_ff;
      pwm_fire            = 1'b0;
      freq                = 8'd0;

      if (csr_valid) begin
         case (csr_index)
            REG_MIN_FREQ: min_freq_in = csr_wdata;
            REG_MAX_FREQ: max_freq_in = csr_wdata;
            REG_DUAL:     dual_in     = csr_wdata[0];
            default:      ;
         endcase
      end

      case (state_ff)
         S_IDLE: ;
         S_MUL: begin
            // MSB-first shift-add: (duty - 10) * |max - min|
            quo_in    = {quo_ff[13:0], 1'b0} + (mplier_ff[6] ? {7'd0, divisor_ff} : 15'd0);
            mplier_in = {mplier_ff[5:0], 1'b0};
            cnt_in    = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               state_in     = S_DIV;
               div_phase_in = 1'b0;
               divisor_in   = DUTY_SPAN;
               rem_in       = 8'd0;
               cnt_in       = DIV_LAST;
            end
         end
         S_DIV: begin
            rem_in = trial_neg ? {rem_ff[6:0], quo_ff[14]} : trial[7:0];
            quo_in = {quo_ff[13:0], !trial_neg};
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               if (!div_phase_ff) begin
                  // quotient is final in quo_in; map it to the frequency now
                  state_in     = S_DIV;
                  div_phase_in = 1'b1;
                  cnt_in       = DIV_LAST;
                  rem_in       = 8'd0;
                  freq         = neg_ff ? (min_freq_ff - quo_in[7:0])
                                        : (min_freq_ff + quo_in[7:0]);
                  divisor_in   = (freq == 8'd0) ? 8'd1 : freq;
                  quo_in       = PERIOD_US;
               end else begin
                  pending_interval_in = quo_in[13:0];
                  state_in            = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (req_take) begin
         case (req_data.kind)
            KIND_TICK: begin
               elapsed_in = elapsed_inc;
               if (elapsed_inc >= active_interval_ff) begin
                  elapsed_in = 14'd0;
                  pwm_fire   = (step_ff == 7'd0) && (pending_duty_ff != 7'd0);
                  if (pwm_fire) begin
                     if (en_ff) begin
                        if (speed_held_ff != 8'd0 && !speed_held_ff[7]) begin
                           fwd_in = 1'b1;
                        end else if (speed_held_ff[7] && dual_ff) begin
                           rev_in = 1'b1;
                        end
                     end
                     active_duty_in     = pending_duty_ff;
                     active_interval_in = pending_interval_ff;
                  end
                  if (step_ff == active_duty_in) begin
                     fwd_in = 1'b0;
                     if (dual_ff) begin
                        rev_in = 1'b0;
                     end
                  end
                  step_in = (step_ff >= DUTY_MAX) ? 7'd0 : step_ff + 7'd1;
               end
            end
            KIND_SPEED: begin
               speed_held_in   = req_data.speed;
               pending_duty_in = duty;
               neg_in          = max_freq_ff < min_freq_ff;
               if (duty <= DUTY_KNEE) begin
                  // frequency is min_frequency; go straight to 10000 / f
                  state_in     = S_DIV;
                  div_phase_in = 1'b1;
                  cnt_in       = DIV_LAST;
                  rem_in       = 8'd0;
                  quo_in       = PERIOD_US;
                  divisor_in   = (min_freq_ff == 8'd0) ? 8'd1 : min_freq_ff;
               end else begin
                  state_in   = S_MUL;
                  cnt_in     = MUL_LAST;
                  quo_in     = 15'd0;
                  mplier_in  = duty - DUTY_KNEE;
                  divisor_in = (max_freq_ff < min_freq_ff) ? (min_freq_ff - max_freq_ff)
                                                           : (max_freq_ff - min_freq_ff);
               end
            end
            KIND_ENABLE: begin
               en_in = req_data.enable;
               if (req_data.enable) begin
                  step_in = 7'd0;
               end else begin
                  fwd_in = 1'b0;
                  if (dual_ff) begin
                     rev_in = 1'b0;
                  end
               end
            end
            default: ;
         endcase
         rsp_valid_in            = 1'b1;
         rsp_data_in.forward_out = fwd_in;
         rsp_data_in.reverse_out = rev_in;
         rsp_data_in.enabled     = en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_freq_ff         <= MIN_FREQ_RESET;
         max_freq_ff         <= MAX_FREQ_RESET;
         dual_ff             <= 1'b0;
         step_ff             <= 7'd0;
         active_duty_ff      <= 7'd0;
         active_interval_ff  <= 14'd0;
         pending_duty_ff     <= 7'd0;
         pending_interval_ff <= 14'd0;
         speed_held_ff       <= 8'd0;
         elapsed_ff          <= 14'd0;
         fwd_ff              <= 1'b0;
         rev_ff              <= 1'b0;
         en_ff               <= 1'b0;
         state_ff            <= S_IDLE;
         rsp_valid_ff        <= 1'b0;
      end else begin
         min_freq_ff         <= min_freq_in;
         max_freq_ff         <= max_freq_in;
         dual_ff             <= dual_in;
         step_ff             <= step_in;
         active_duty_ff      <= active_duty_in;
         active_interval_ff  <= active_interval_in;
         pending_duty_ff     <= pending_duty_in;
         pending_interval_ff <= pending_interval_in;
         speed_held_ff       <= speed_held_in;
         elapsed_ff          <= elapsed_in;
         fwd_ff              <= fwd_in;
         rev_ff              <= rev_in;
         en_ff               <= en_in;
         state_ff            <= state_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      div_phase_ff <= div_phase_in;
      neg_ff       <= neg_in;
      cnt_ff       <= cnt_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      divisor_ff   <= divisor_in;
      mplier_ff    <= mplier_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // freq_sum mirrors the end-of-divide frequency; check they agree
   ap_freq_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && div_phase_ff && cnt_ff == DIV_LAST && $past(state_ff) == S_DIV)
      |-> (divisor_ff == (($past(freq_sum[7:0]) == 8'd0) ? 8'd1 : $past(freq_sum[7:0]))))
      else $error("frequency handoff mismatch");

   ap_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready)
      else $error("item accepted while engine busy");

   ap_step_range: assert property (@(posedge clock) disable iff (reset)
      (step_ff <= DUTY_MAX) && (active_duty_ff <= DUTY_MAX) && (pending_duty_ff <= DUTY_MAX))
      else $error("step or duty out of range");

   ap_interval_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && div_phase_ff && cnt_ff == 4'd0) |=> (pending_interval_ff != 14'd0))
      else $error("zero interval computed");

endmodule
